/* src/lmsbs_pkg.sv */
// Shared types and constants of the LED matrix scanner with blink and scroll.
package lmsbs_pkg;

  // Item kinds carried on the input tuser.
  localparam logic [2:0] FUNC_TICK       = 3'd0;
  localparam logic [2:0] FUNC_SET_LED    = 3'd1;
  localparam logic [2:0] FUNC_SET_DIGITS = 3'd2;
  localparam logic [2:0] FUNC_LOAD_ENTRY = 3'd3;
  localparam logic [2:0] FUNC_START      = 3'd4;
  localparam logic [2:0] FUNC_CLEAR      = 3'd5;

  // Configuration register indexes.
  localparam logic [7:0] REG_BLINK_HALF  = 8'd0;
  localparam logic [7:0] REG_SCROLL_RATE = 8'd1;

  localparam logic [7:0] BLINK_HALF_RESET  = 8'd20;
  localparam logic [7:0] SCROLL_RATE_RESET = 8'd15;

  localparam logic [7:0] SEG_MASK    = 8'h7f;
  localparam logic [7:0] SIDE_LED    = 8'h80;

  localparam logic [1:0] COL_LEDS  = 2'd0;
  localparam logic [1:0] COL_LEFT  = 2'd1;
  localparam logic [1:0] COL_RIGHT = 2'd2;

  localparam int IN_DATA_W  = 56;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 16;

  // Tick in flight between the memory read and the output register.
  typedef struct packed {
    logic [1:0] col;
    logic       use_mem;
    logic       hi;
    logic [7:0] pre;
  } stage_t;

endpackage

/* src/led_matrix_scan_blink_scroll.sv */
// Top level of the LED matrix scanner with blink and scroll.
// Scans a three-column LED matrix: each tick item yields one result item carrying the
// strobed column and its row byte, and other items set LEDs, digits, scroll buffer
// entries, start a scroll or clear. The block accepts one item per clock while in_tready is
// high; a tick's result passes through a read stage and then into the output register; the
// read stage covers the registered read of the scroll buffer memory that supplies the digit
// segments while scrolling. The input side waits only while a tick holds the read stage
// and the output register is full and not being taken.
module led_matrix_scan_blink_scroll #(
  parameter int SCROLL_DEPTH = 64,
  parameter int DOT_BIT      = 9,
  parameter int TUNE_BIT     = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // Fields from bit 0: full_update, led_index[3:0], led_on_bit, led_blink_bit,
  // left_segments[7:0], right_segments[7:0], entry_index[5:0], entry_segments[7:0],
  // scroll_length[6:0], scroll_passes[7:0], zero padding.
  input  logic [lmsbs_pkg::IN_DATA_W-1:0]   in_tdata,
  // Fields from bit 0: func[2:0].
  input  logic [lmsbs_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // Fields from bit 0: column_index[1:0], row_bits[7:0], zero padding.
  output logic [lmsbs_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [7:0]                        cfg_index,
  input  logic [7:0]                        cfg_data
);
  import lmsbs_pkg::*;

  localparam int AW = (SCROLL_DEPTH > 1) ? $clog2(SCROLL_DEPTH) : 1;
  localparam int UW = $clog2(SCROLL_DEPTH + 1);

  // Input fields.
  logic [2:0] func;
  logic       full_update;
  logic [3:0] led_index;
  logic       led_on_bit, led_blink_bit;
  logic [7:0] left_segments, right_segments, entry_segments, scroll_passes;
  logic [5:0] entry_index;
  logic [6:0] scroll_length;

  assign func           = in_tuser[2:0];
  assign full_update    = in_tdata[0];
  assign led_index      = in_tdata[4:1];
  assign led_on_bit     = in_tdata[5];
  assign led_blink_bit  = in_tdata[6];
  assign left_segments  = in_tdata[14:7];
  assign right_segments = in_tdata[22:15];
  assign entry_index    = in_tdata[28:23];
  assign entry_segments = in_tdata[36:29];
  assign scroll_length  = in_tdata[43:37];
  assign scroll_passes  = in_tdata[51:44];

  // State.
  logic [7:0]    blink_half_r, scroll_rate_r;
  logic [15:0]   led_on_r, led_on_nxt, led_blink_r, led_blink_nxt;
  logic [7:0]    digit0_r, digit0_nxt, digit1_r, digit1_nxt;
  logic [7:0]    blink_count_r, blink_count_nxt;
  logic          blink_phase_r, blink_phase_nxt;
  logic [7:0]    scroll_count_r, scroll_count_nxt;
  logic [AW-1:0] scroll_pos_r, scroll_pos_nxt;
  logic [UW-1:0] scroll_used_r, scroll_used_nxt;
  logic [7:0]    passes_r, passes_nxt;
  logic [1:0]    col_r, col_nxt;
  logic [7:0]    row_store_r [3];
  logic          s1_valid_r, s1_valid_nxt;
  stage_t        s1_r, s1_nxt;
  logic          out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // Scroll buffer memory.
  logic [7:0]    scroll_mem [SCROLL_DEPTH];
  logic [7:0]    mem_q_r;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;

  logic          accept, s1_adv;
  logic [7:0]    s1_row;
  logic [15:0]   led_sel;
  logic [7:0]    blink_inc, scroll_inc;
  logic [UW-1:0] pos_plus;
  logic [AW-1:0] pos_next;
  logic          scrolling;

  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // While scrolling, column 1 shows the current position and column 2 the next one.
  assign scrolling = (passes_r != 8'd0);
  assign pos_plus  = UW'(scroll_pos_r) + UW'(1);
  assign pos_next  = (pos_plus == scroll_used_r) ? AW'(0) : AW'(pos_plus);

  assign s1_row = s1_r.use_mem ? ({s1_r.hi, 7'd0} | (mem_q_r & SEG_MASK)) : s1_r.pre;

  always_comb begin
    led_on_nxt       = led_on_r;
    led_blink_nxt    = led_blink_r;
    digit0_nxt       = digit0_r;
    digit1_nxt       = digit1_r;
    blink_count_nxt  = blink_count_r;
    blink_phase_nxt  = blink_phase_r;
    scroll_count_nxt = scroll_count_r;
    scroll_pos_nxt   = scroll_pos_r;
    scroll_used_nxt  = scroll_used_r;
    passes_nxt       = passes_r;
    col_nxt          = col_r;
    s1_valid_nxt     = s1_valid_r && !s1_adv;
    s1_nxt           = s1_r;
    mem_we           = 1'b0;
    mem_re           = 1'b0;
    mem_waddr        = AW'(entry_index);
    mem_raddr        = scroll_pos_r;
    led_sel          = 16'd1 << led_index;
    blink_inc        = blink_count_r + 8'd1;
    scroll_inc       = scroll_count_r + 8'd1;

    if (accept) begin
      case (func)
        FUNC_TICK: begin
          s1_valid_nxt = 1'b1;
          s1_nxt.col     = col_r;
          s1_nxt.use_mem = 1'b0;
          s1_nxt.hi      = 1'b0;
          s1_nxt.pre     = row_store_r[col_r];
          col_nxt        = (col_r == COL_RIGHT) ? COL_LEDS : col_r + 2'd1;
          if (full_update) begin
            blink_count_nxt = blink_inc;
            if (blink_inc > blink_half_r) begin
              blink_phase_nxt = !blink_phase_r;
              blink_count_nxt = 8'd0;
            end
            if (scrolling) begin
              scroll_count_nxt = scroll_inc;
              if (scroll_inc > scroll_rate_r) begin
                scroll_pos_nxt   = pos_next;
                scroll_count_nxt = 8'd0;
                if (pos_next == AW'(0) && !passes_r[7]) begin
                  passes_nxt = passes_r - 8'd1;
                end
              end
            end
            case (col_r)
              COL_LEDS: begin
                s1_nxt.pre = led_on_r[7:0]
                           ^ (blink_phase_nxt ? led_blink_r[7:0] : 8'd0);
              end
              COL_LEFT: begin
                s1_nxt.hi  = led_on_r[DOT_BIT] ^ (led_blink_r[DOT_BIT] & blink_phase_nxt);
                s1_nxt.pre = {s1_nxt.hi, 7'd0} | (digit0_r & SEG_MASK);
                s1_nxt.use_mem = scrolling;
                mem_raddr      = scroll_pos_r;
                mem_re         = scrolling;
              end
              default: begin
                s1_nxt.hi  = led_on_r[TUNE_BIT]
                           ^ (led_blink_r[TUNE_BIT] & blink_phase_nxt);
                s1_nxt.pre = {s1_nxt.hi, 7'd0} | (digit1_r & SEG_MASK);
                s1_nxt.use_mem = scrolling;
                mem_raddr      = pos_next;
                mem_re         = scrolling;
              end
            endcase
          end
        end
        FUNC_SET_LED: begin
          if (!led_blink_bit) led_blink_nxt = led_blink_r & ~led_sel;
          if (led_on_bit) begin
            led_on_nxt = led_on_r | led_sel;
            if (led_blink_bit) led_blink_nxt = led_blink_r | led_sel;
          end else begin
            led_on_nxt = led_on_r & ~led_sel;
          end
        end
        FUNC_SET_DIGITS: begin
          digit0_nxt = left_segments;
          digit1_nxt = right_segments;
        end
        FUNC_LOAD_ENTRY: begin
          mem_we = (32'(entry_index) < SCROLL_DEPTH);
        end
        FUNC_START: begin
          if (scroll_length == 7'd0) begin
            scroll_used_nxt = UW'(1);
          end else if (32'(scroll_length) > SCROLL_DEPTH) begin
            scroll_used_nxt = UW'(SCROLL_DEPTH);
          end else begin
            scroll_used_nxt = UW'(scroll_length);
          end
          scroll_pos_nxt = AW'(0);
          passes_nxt     = scroll_passes;
        end
        FUNC_CLEAR: begin
          digit0_nxt    = 8'd0;
          digit1_nxt    = 8'd0;
          led_on_nxt    = 16'd0;
          led_blink_nxt = 16'd0;
          passes_nxt    = 8'd0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      scroll_mem[mem_waddr] <= entry_segments;
    end
    if (mem_re) begin
      mem_q_r <= scroll_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_half_r   <= BLINK_HALF_RESET;
      scroll_rate_r  <= SCROLL_RATE_RESET;
      led_on_r       <= 16'd0;
      led_blink_r    <= 16'd0;
      digit0_r       <= 8'd0;
      digit1_r       <= 8'd0;
      blink_count_r  <= 8'd0;
      blink_phase_r  <= 1'b0;
      scroll_count_r <= 8'd0;
      scroll_pos_r   <= AW'(0);
      scroll_used_r  <= UW'(1);
      passes_r       <= 8'd0;
      col_r          <= COL_LEDS;
      row_store_r[0] <= 8'd0;
      row_store_r[1] <= 8'd0;
      row_store_r[2] <= 8'd0;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_BLINK_HALF) blink_half_r <= cfg_data;
        if (cfg_index == REG_SCROLL_RATE) scroll_rate_r <= cfg_data;
      end
      led_on_r       <= led_on_nxt;
      led_blink_r    <= led_blink_nxt;
      digit0_r       <= digit0_nxt;
      digit1_r       <= digit1_nxt;
      blink_count_r  <= blink_count_nxt;
      blink_phase_r  <= blink_phase_nxt;
      scroll_count_r <= scroll_count_nxt;
      scroll_pos_r   <= scroll_pos_nxt;
      scroll_used_r  <= scroll_used_nxt;
      passes_r       <= passes_nxt;
      col_r          <= col_nxt;
      s1_valid_r     <= s1_valid_nxt;
      // The finished row byte is stored back when the tick leaves for the output register.
      if (s1_valid_r && s1_adv) begin
        row_store_r[s1_r.col] <= s1_row;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
    if (s1_valid_r && s1_adv) begin
      out_data_r <= {6'd0, s1_row, s1_r.col};
    end
  end

endmodule

/* tb/lmsbs_tb_pkg.sv */
// Item layout and spare function codes shared by the scanner testbench files.
`timescale 1ns / 1ps
package lmsbs_tb_pkg;

  // Function codes that the block ignores.
  localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [2:0] FUNC_SPARE_7 = 3'd7;

  // Input tdata fields, last declared member in the lowest bits.
  typedef struct packed {
    logic [3:0] pad;
    logic [7:0] passes;
    logic [6:0] len;
    logic [7:0] eseg;
    logic [5:0] eidx;
    logic [7:0] right;
    logic [7:0] left;
    logic       blink;
    logic       on;
    logic [3:0] led;
    logic       full;
  } item_fields_t;

endpackage

/* tb/lmsbs_checker.sv */
// Watches the scanner's channels, predicts every strobe and compares it with the output.
`timescale 1ns / 1ps
module lmsbs_checker #(
  parameter int SCROLL_DEPTH = 64,
  parameter int DOT_BIT      = 9,
  parameter int TUNE_BIT     = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [lmsbs_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic [lmsbs_pkg::IN_USER_W-1:0]   in_tuser,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [lmsbs_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [7:0]                        cfg_index,
  input  logic [7:0]                        cfg_data,
  output int                                fail_count,
  output int                                outstanding
);
  import lmsbs_pkg::*;
  import lmsbs_tb_pkg::*;

  typedef struct {
    logic [1:0] col;
    logic [7:0] row;
  } strobe_t;

  strobe_t    expected_strobes[$];
  int         mismatches;

  logic [7:0] blink_half;
  logic [7:0] scroll_rate;
  logic [15:0] on_mask;
  logic [15:0] blink_mask;
  logic [7:0] digits[2];
  logic [7:0] blink_cnt;
  logic       blink_ph;
  logic [7:0] scroll_cnt;
  int         scroll_pos;
  int         scroll_len;
  logic [7:0] passes_left;
  logic [1:0] col;
  logic [7:0] rows[3];
  logic [7:0] scroll_mem[SCROLL_DEPTH];

  function automatic logic [7:0] side_row(input logic [7:0] seg, input int led_bit);
    logic [7:0] b;
    b = seg & SEG_MASK;
    if (on_mask[led_bit]) b = b | SIDE_LED;
    if (blink_mask[led_bit] && blink_ph) b = b ^ SIDE_LED;
    return b;
  endfunction

  // Full update: step the blink timer and the scroller, then rebuild the active row.
  task automatic refresh_column();
    logic [7:0] shown[2];
    logic [7:0] b;
    int p;
    int q;
    blink_cnt = blink_cnt + 8'd1;
    if (blink_cnt > blink_half) begin
      blink_ph  = ~blink_ph;
      blink_cnt = '0;
    end
    if (passes_left != 0) begin
      p = scroll_pos % scroll_len;
      q = (p + 1) % scroll_len;
      scroll_cnt = scroll_cnt + 8'd1;
      shown[0] = scroll_mem[p];
      shown[1] = scroll_mem[q];
      if (scroll_cnt > scroll_rate) begin
        scroll_pos = q;
        scroll_cnt = '0;
        // Only a positive count runs down; a negative one scrolls forever.
        if (q == 0 && !passes_left[7]) passes_left = passes_left - 8'd1;
      end
    end else begin
      shown[0] = digits[0];
      shown[1] = digits[1];
    end
    case (col)
      COL_LEDS: b = on_mask[7:0] ^ (blink_ph ? blink_mask[7:0] : 8'h00);
      COL_LEFT: b = side_row(shown[0], DOT_BIT);
      default:  b = side_row(shown[1], TUNE_BIT);
    endcase
    rows[col] = b;
  endtask

  task automatic take_item(input logic [2:0] f, input item_fields_t it);
    logic [15:0] m;
    int len;
    strobe_t s;
    case (f)
      FUNC_TICK: begin
        if (it.full) refresh_column();
        s.col = col;
        s.row = rows[col];
        expected_strobes.push_back(s);
        col = (col == COL_RIGHT) ? COL_LEDS : col + 2'd1;
      end
      FUNC_SET_LED: begin
        m = 16'd1 << it.led;
        if (!it.blink) blink_mask = blink_mask & ~m;
        if (it.on) begin
          on_mask = on_mask | m;
          if (it.blink) blink_mask = blink_mask | m;
        end else begin
          on_mask = on_mask & ~m;
        end
      end
      FUNC_SET_DIGITS: begin
        digits[0] = it.left;
        digits[1] = it.right;
      end
      FUNC_LOAD_ENTRY: begin
        if (it.eidx < SCROLL_DEPTH) scroll_mem[it.eidx] = it.eseg;
      end
      FUNC_START: begin
        len = int'(it.len);
        if (len < 1) len = 1;
        if (len > SCROLL_DEPTH) len = SCROLL_DEPTH;
        scroll_len  = len;
        scroll_pos  = 0;
        passes_left = it.passes;
      end
      FUNC_CLEAR: begin
        digits[0]   = '0;
        digits[1]   = '0;
        on_mask     = '0;
        blink_mask  = '0;
        passes_left = '0;
      end
      default: ;
    endcase
  endtask

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t ns: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    strobe_t got;
    strobe_t want;
    if (!rst_n) begin
      expected_strobes.delete();
      blink_half  = BLINK_HALF_RESET;
      scroll_rate = SCROLL_RATE_RESET;
      on_mask     = '0;
      blink_mask  = '0;
      digits[0]   = '0;
      digits[1]   = '0;
      blink_cnt   = '0;
      blink_ph    = 1'b0;
      scroll_cnt  = '0;
      scroll_pos  = 0;
      scroll_len  = 1;
      passes_left = '0;
      col         = COL_LEDS;
      foreach (rows[i]) rows[i] = '0;
      foreach (scroll_mem[i]) scroll_mem[i] = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BLINK_HALF:  blink_half  = cfg_data;
          REG_SCROLL_RATE: scroll_rate = cfg_data;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.col = out_tdata[1:0];
        got.row = out_tdata[9:2];
        if (expected_strobes.size() == 0) begin
          note_mismatch($sformatf("unexpected item: column %0d row %02h", got.col, got.row));
        end else begin
          want = expected_strobes.pop_front();
          if (got.col != want.col)
            note_mismatch($sformatf("column_index expected %0d got %0d", want.col, got.col));
          if (got.row != want.row)
            note_mismatch($sformatf("row_bits (column %0d) expected %02h got %02h",
                                    want.col, want.row, got.row));
        end
      end
      if (in_tvalid && in_tready) take_item(in_tuser, item_fields_t'(in_tdata));
    end
    outstanding <= expected_strobes.size();
    fail_count  <= mismatches;
  end

endmodule

/* tb/led_matrix_scan_blink_scroll_test.sv */
// Top of the scanner testbench: clock, reset, stimulus, receiver stalls and the verdict.
`timescale 1ns / 1ps
module led_matrix_scan_blink_scroll_test;
  import lmsbs_pkg::*;
  import lmsbs_tb_pkg::*;

  localparam int SCROLL_DEPTH = 64;
  localparam int DOT_BIT      = 9;
  localparam int TUNE_BIT     = 8;
  localparam int STALL_LIMIT  = 4000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [IN_USER_W-1:0]  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [7:0]            cfg_index;
  logic [7:0]            cfg_data;
  int                    fail_count;
  int                    outstanding;

  int   src_idle;
  int   sink_idle;
  int   useful_items;
  int   quiet_cycles;
  logic loaded[SCROLL_DEPTH];

  led_matrix_scan_blink_scroll #(
    .SCROLL_DEPTH(SCROLL_DEPTH),
    .DOT_BIT     (DOT_BIT),
    .TUNE_BIT    (TUNE_BIT)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lmsbs_checker #(
    .SCROLL_DEPTH(SCROLL_DEPTH),
    .DOT_BIT     (DOT_BIT),
    .TUNE_BIT    (TUNE_BIT)
  ) strobe_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= sink_idle);
  end

  // Ends the run when no channel has moved an item for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Random content in every field but the padding, so that unused fields toggle too.
  function automatic item_fields_t noise();
    logic [63:0] raw;
    item_fields_t it;
    raw = {$urandom, $urandom};
    it = raw[55:0];
    it.pad = '0;
    return it;
  endfunction

  task automatic send_item(input logic [2:0] f, input item_fields_t it);
    while ($urandom_range(0, 99) < src_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= it;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (f == FUNC_LOAD_ENTRY) loaded[it.eidx] = 1'b1;
    if (f != FUNC_SPARE_6 && f != FUNC_SPARE_7) useful_items++;
  endtask

  task automatic tick(input logic full);
    item_fields_t it;
    it = noise();
    it.full = full;
    send_item(FUNC_TICK, it);
  endtask

  task automatic set_led(input logic [3:0] idx, input logic on, input logic blink);
    item_fields_t it;
    it = noise();
    it.led   = idx;
    it.on    = on;
    it.blink = blink;
    send_item(FUNC_SET_LED, it);
  endtask

  task automatic set_digits(input logic [7:0] left, input logic [7:0] right);
    item_fields_t it;
    it = noise();
    it.left  = left;
    it.right = right;
    send_item(FUNC_SET_DIGITS, it);
  endtask

  task automatic load_entry(input logic [5:0] idx, input logic [7:0] seg);
    item_fields_t it;
    it = noise();
    it.eidx = idx;
    it.eseg = seg;
    send_item(FUNC_LOAD_ENTRY, it);
  endtask

  // A running scroll reads entries 0 to span-1, so unloaded ones get loaded first.
  task automatic start_scroll(input logic [6:0] len, input logic [7:0] passes);
    item_fields_t it;
    int span;
    span = (len < 1) ? 1 : (len > SCROLL_DEPTH) ? SCROLL_DEPTH : int'(len);
    if (passes != 0) begin
      for (int i = 0; i < span; i++) begin
        if (!loaded[i]) load_entry(6'(i), 8'($urandom));
      end
    end
    it = noise();
    it.len    = len;
    it.passes = passes;
    send_item(FUNC_START, it);
  endtask

  task automatic send_random();
    int r;
    int k;
    logic [6:0] len;
    logic [7:0] passes;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      tick($urandom_range(0, 9) < 8);
    end else if (r < 65) begin
      set_led(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
    end else if (r < 72) begin
      set_digits(8'($urandom), 8'($urandom));
    end else if (r < 82) begin
      load_entry(6'($urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 63)),
                 8'($urandom));
    end else if (r < 89) begin
      k = $urandom_range(0, 99);
      if (k < 70) len = 7'($urandom_range(1, 6));
      else if (k < 90) len = 7'($urandom_range(0, 63));
      else len = 7'($urandom_range(64, 127));
      k = $urandom_range(0, 99);
      if (k < 50) passes = 8'($urandom_range(1, 3));
      else if (k < 70) passes = 8'($urandom_range(128, 255));
      else if (k < 85) passes = '0;
      else passes = 8'($urandom_range(0, 255));
      start_scroll(len, passes);
    end else if (r < 94) begin
      send_item(FUNC_CLEAR, noise());
    end else begin
      send_item($urandom_range(0, 1) ? FUNC_SPARE_6 : FUNC_SPARE_7, noise());
    end
  endtask

  task automatic run_random(input int count);
    int target;
    target = useful_items + count;
    while (useful_items < target) send_random();
  endtask

  // Holds the sender until every strobe is back and the pipeline has emptied.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_tvalid    <= 1'b0;
    in_tdata     <= '0;
    in_tuser     <= FUNC_TICK;
    cfg_valid    <= 1'b0;
    cfg_index    <= REG_BLINK_HALF;
    cfg_data     <= '0;
    src_idle     = 31;
    sink_idle    = 64;
    useful_items = 0;
    foreach (loaded[i]) loaded[i] = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, with the register values from reset.
    tick(1'b0);
    set_led(4'd0, 1'b1, 1'b1);
    set_led(4'd15, 1'b1, 1'b0);
    set_led(4'(DOT_BIT), 1'b1, 1'b1);
    set_led(4'(TUNE_BIT), 1'b1, 1'b0);
    set_led(4'd15, 1'b0, 1'b1);
    set_digits(8'hff, 8'h80);
    repeat (3) tick(1'b1);
    load_entry(6'd0, 8'h3f);
    load_entry(6'd63, 8'hff);
    load_entry(6'd1, 8'h06);
    // A zero length acts as one.
    start_scroll(7'd0, 8'd1);
    repeat (3) tick(1'b1);
    // Most negative pass count: scrolls without end.
    start_scroll(7'd2, 8'h80);
    repeat (3) tick(1'b1);
    send_item(FUNC_SPARE_6, noise());
    send_item(FUNC_SPARE_7, noise());
    send_item(FUNC_CLEAR, noise());
    tick(1'b1);
    // Oversized length saturates, and zero passes stops the scroll.
    start_scroll(7'd127, 8'd0);
    tick(1'b1);
    settle();

    write_reg(REG_BLINK_HALF, 8'd0);
    write_reg(REG_SCROLL_RATE, 8'd0);
    run_random(100);
    settle();

    src_idle  = 64;
    sink_idle = 31;
    // With limits of 255 the counters wrap and never fire.
    write_reg(REG_BLINK_HALF, 8'd255);
    write_reg(REG_SCROLL_RATE, 8'd255);
    run_random(100);
    settle();

    src_idle  = 0;
    sink_idle = 0;
    write_reg(REG_BLINK_HALF, 8'd3);
    write_reg(REG_SCROLL_RATE, 8'd2);
    run_random(100);
    settle();

    write_reg(REG_BLINK_HALF, 8'($urandom_range(0, 15)));
    write_reg(REG_SCROLL_RATE, 8'($urandom_range(0, 15)));
    run_random(100);
    settle();

    if (fail_count == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* led_matrix_scan_blink_scroll.f */
src/lmsbs_pkg.sv
src/led_matrix_scan_blink_scroll.sv
tb/lmsbs_tb_pkg.sv
tb/lmsbs_checker.sv
tb/led_matrix_scan_blink_scroll_test.sv
